@@ rtl/core/ewf_pkg.sv @@
// ----------------------------------------------------------------------------
// ewf_pkg
// Shared types, constants and lookup tables for the envelope/LFO wah core.
// ----------------------------------------------------------------------------
package ewf_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SWEEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ     = 3'd7;

    localparam logic        RST_AUTO_SWEEP  = 1'b1;
    localparam logic [15:0] RST_PEDAL       = 16'd42598;
    localparam logic [15:0] RST_SENSITIVITY = 16'd45875;
    localparam logic [23:0] RST_ATTACK      = 24'd16707457;
    localparam logic [23:0] RST_RELEASE     = 24'd16774527;
    localparam logic [23:0] RST_LFO_STEP    = 24'd740;
    localparam logic [23:0] RST_HIGHPASS    = 24'd16571200;
    localparam logic [23:0] RST_BASE_FREQ   = 24'd122333;

    localparam logic [23:0] FREQ_CAP = 24'd7214203;

    // divider: quotient, numerator and divisor widths and numerator exponents
    localparam int DIV_QW  = 26;
    localparam int DIV_NW  = 57;
    localparam int DIV_DW  = 34;
    localparam int KQ_EXP  = 40;
    localparam int R_EXP   = 56;

    localparam int MUL_W = 36;
    localparam int PRD_W = 2 * MUL_W;
    localparam int SAT_W = 74;

    localparam logic [16:0] SIN_TAB [17] = '{
        17'd0,     17'd6424,  17'd12785, 17'd19024, 17'd25080, 17'd30893,
        17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
        17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

    localparam logic [17:0] EXP_TAB [17] = '{
        18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
        18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    typedef enum logic [5:0] {
        ST_QQ, ST_KQ_GO, ST_ENV1, ST_ENV2, ST_GAIN, ST_PICK,
        ST_SIN_PH, ST_LFO, ST_BASE, ST_DEPTH, ST_POS1,
        ST_K1, ST_POS2, ST_P2, ST_SHAPE, ST_EXPARG, ST_EXP, ST_FN,
        ST_SN, ST_CS, ST_SN2, ST_CS2, ST_SC, ST_KQ_GET, ST_DEN,
        ST_R_GO, ST_R_GET, ST_A1, ST_A2, ST_GA2,
        ST_BP1, ST_BP2, ST_LP1, ST_LP2, ST_KG1, ST_KG2,
        ST_WAH, ST_DRY, ST_HP, ST_OUT
    } t_step;

    typedef struct packed {
        logic  load;
        logic  en;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic auto_sweep;
        logic div_busy;
    } t_stat;

    function automatic logic [23:0] f_sin_fold(input logic [23:0] v);
        logic [23:0] w;
        w = (v > 24'h800000) ? 24'(25'h1000000 - 25'(v)) : v;
        return w;
    endfunction

    function automatic logic [16:0] f_sin_base(input logic [4:0] idx);
        logic [16:0] b;
        b = idx[4] ? SIN_TAB[16] : SIN_TAB[{1'b0, idx[3:0]}];
        return b;
    endfunction

    function automatic logic [12:0] f_sin_diff(input logic [4:0] idx);
        logic [16:0] d;
        d = idx[4] ? 17'd0
                   : 17'(SIN_TAB[{1'b0, idx[3:0]} + 5'd1] - SIN_TAB[{1'b0, idx[3:0]}]);
        return d[12:0];
    endfunction

    function automatic logic [12:0] f_exp_diff(input logic [3:0] idx);
        logic [17:0] d;
        d = 18'(EXP_TAB[{1'b0, idx} + 5'd1] - EXP_TAB[{1'b0, idx}]);
        return d[12:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_W'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_W'(-64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [23:0] f_sat24(input logic signed [SAT_W-1:0] v);
        logic signed [23:0] r;
        if (v > SAT_W'(64'sd8388607)) begin
            r = 24'sh7FFFFF;
        end else if (v < SAT_W'(-64'sd8388608)) begin
            r = 24'sh800000;
        end else begin
            r = 24'(v);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ewf_div.sv @@
// ----------------------------------------------------------------------------
// ewf_div
// Restoring divider: power of two over a divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ewf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_wide,
    input  logic [ewf_pkg::DIV_DW-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [ewf_pkg::DIV_QW-1:0]   o_quot
);

    localparam int SH_W = ewf_pkg::DIV_DW + ewf_pkg::DIV_QW - 1;
    localparam int CNT_W = $clog2(ewf_pkg::DIV_QW);

    logic [ewf_pkg::DIV_NW-1:0] r_rem;
    logic [SH_W-1:0]            r_dsh;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic [ewf_pkg::DIV_QW-1:0] r_quot;
    logic                       w_ge;

    assign w_ge = SH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_wide ? (ewf_pkg::DIV_NW'(1) << ewf_pkg::R_EXP)
                            : (ewf_pkg::DIV_NW'(1) << ewf_pkg::KQ_EXP);
            r_dsh <= SH_W'(i_divisor) << (ewf_pkg::DIV_QW - 1);
            r_cnt <= CNT_W'(ewf_pkg::DIV_QW - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[ewf_pkg::DIV_NW-1:0];
            end
            r_quot <= {r_quot[ewf_pkg::DIV_QW-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/ewf_datapath.sv @@
// ----------------------------------------------------------------------------
// ewf_datapath
// Knob registers, channel state, shared multiplier, divider and working registers.
// ----------------------------------------------------------------------------
module ewf_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ewf_pkg::t_cmd                     i_cmd,
    output ewf_pkg::t_stat                    o_stat,
    input  logic                              i_channel,
    input  logic signed [23:0]                i_sample_in,
    input  logic                              i_cfg_wr_en,
    input  logic [ewf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ewf_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    output logic                              o_channel_out,
    output logic signed [23:0]                o_sample_out
);

    // knobs
    logic        r_auto;
    logic [15:0] r_pedal, r_sens;
    logic [23:0] r_att, r_rel, r_lfo_step, r_hpc, r_bfn;

    // channel state
    logic signed [31:0] r_ic1_st [ewf_pkg::CHANNELS];
    logic signed [31:0] r_ic2_st [ewf_pkg::CHANNELS];
    logic        [23:0] r_env_st [ewf_pkg::CHANNELS];
    logic        [23:0] r_ph_st  [ewf_pkg::CHANNELS];
    logic signed [31:0] r_hpo_st [ewf_pkg::CHANNELS];
    logic signed [31:0] r_hpi_st [ewf_pkg::CHANNELS];

    // working registers
    logic                      r_ch;
    logic [ewf_pkg::CH_W-1:0]  r_chi;
    logic signed [23:0]        r_x;
    logic signed [31:0]        r_ic1, r_ic2, r_hpo, r_hpi;
    logic [23:0]               r_env, r_ph, r_fn;
    logic signed [ewf_pkg::PRD_W-1:0] r_acc;
    logic [18:0] r_gain, r_qq, r_kgain;
    logic [16:0] r_pick, r_sv, r_lfo, r_depth, r_p2, r_shaped, r_sn, r_cs;
    logic [15:0] r_base;
    logic [17:0] r_pos, r_e;
    logic [13:0] r_t1;
    logic [19:0] r_expv;
    logic [32:0] r_sn2, r_cs2, r_sc;
    logic [33:0] r_den;
    logic [ewf_pkg::DIV_QW-1:0] r_kq, r_r;
    logic [26:0] r_a1, r_a2, r_ga2;
    logic signed [31:0] r_bp, r_lp, r_mixed, r_hp;
    logic [24:0] r_kg;
    logic signed [32:0] r_wah;
    logic               r_out_ch;
    logic signed [23:0] r_out_y;

    // combinational
    logic [ewf_pkg::CH_W-1:0]         w_chi_in;
    logic signed [ewf_pkg::MUL_W-1:0] w_ma, w_mb;
    logic signed [ewf_pkg::PRD_W-1:0] w_prod, w_sum;
    logic [23:0] w_level, w_coef, w_phn, w_sarg, w_sw;
    logic [16:0] w_sin;
    logic [17:0] w_em;
    logic [20:0] w_pv;
    logic [26:0] w_fv;
    logic [17:0] w_pos2;
    logic signed [32:0] w_v3;
    logic signed [33:0] w_hpsum, w_ic1n, w_ic2n;
    logic        w_div_start, w_div_busy;
    logic [ewf_pkg::DIV_QW-1:0] w_div_q;
    logic [ewf_pkg::DIV_DW-1:0] w_div_d;
    logic        w_run;

    assign w_run    = i_cmd.en;
    assign w_chi_in = (ewf_pkg::CHANNELS > 1) ? ewf_pkg::CH_W'(i_channel) : '0;

    assign w_level = r_x[23] ? 24'(-(25'(r_x))) : 24'(r_x);
    assign w_coef  = (w_level > r_env) ? r_att : r_rel;
    assign w_phn   = r_ph + r_lfo_step;
    assign w_v3    = 33'(r_x) - 33'(r_ic2);
    assign w_hpsum = 34'(r_hpo) + 34'(r_mixed) - 34'(r_hpi);
    assign w_ic1n  = (34'(r_bp) <<< 1) - 34'(r_ic1);
    assign w_ic2n  = (34'(r_lp) <<< 1) - 34'(r_ic2);

    always_comb begin
        case (i_cmd.step)
            ewf_pkg::ST_SN: w_sarg = r_fn;
            ewf_pkg::ST_CS: w_sarg = 24'h800000 - r_fn;
            default:        w_sarg = w_phn;
        endcase
    end
    assign w_sw = ewf_pkg::f_sin_fold(w_sarg);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.step)
            ewf_pkg::ST_QQ:     begin w_ma = 36'(170394);        w_mb = 36'(r_sens);   end
            ewf_pkg::ST_ENV1:   begin w_ma = 36'(w_coef);        w_mb = 36'(r_env);    end
            ewf_pkg::ST_ENV2:   begin
                w_ma = 36'(25'h1000000 - 25'(w_coef));
                w_mb = 36'(w_level);
            end
            ewf_pkg::ST_GAIN:   begin w_ma = 36'(183501);        w_mb = 36'(r_sens);   end
            ewf_pkg::ST_PICK:   begin w_ma = 36'(r_env);         w_mb = 36'(r_gain);   end
            ewf_pkg::ST_SIN_PH,
            ewf_pkg::ST_SN,
            ewf_pkg::ST_CS:     begin
                w_ma = 36'(ewf_pkg::f_sin_diff(w_sw[23:19]));
                w_mb = 36'(w_sw[18:0]);
            end
            ewf_pkg::ST_LFO:    begin w_ma = 36'(r_sv);          w_mb = 36'(r_sv);     end
            ewf_pkg::ST_BASE:   begin w_ma = 36'(14418);         w_mb = 36'(r_pedal);  end
            ewf_pkg::ST_DEPTH:  begin w_ma = 36'(19661);         w_mb = 36'(r_sens);   end
            ewf_pkg::ST_POS1:   begin w_ma = 36'(r_depth);       w_mb = 36'(r_lfo);    end
            ewf_pkg::ST_K1:     begin
                w_ma = r_auto ? 36'(9175) : 36'(11796);
                w_mb = 36'(r_sens);
            end
            ewf_pkg::ST_POS2:   begin w_ma = 36'(r_t1);          w_mb = 36'(r_pick);   end
            ewf_pkg::ST_P2:     begin w_ma = 36'(r_pos);         w_mb = 36'(r_pos);    end
            ewf_pkg::ST_SHAPE:  begin
                w_ma = 36'(r_p2);
                w_mb = 36'(18'd196608 - (r_pos << 1));
            end
            ewf_pkg::ST_EXPARG: begin w_ma = 36'(r_shaped);      w_mb = 36'(173268);   end
            ewf_pkg::ST_EXP:    begin
                w_ma = 36'(ewf_pkg::f_exp_diff(r_e[15:12]));
                w_mb = 36'(r_e[11:0]);
            end
            ewf_pkg::ST_FN:     begin w_ma = 36'(r_bfn);         w_mb = 36'(r_expv);   end
            ewf_pkg::ST_SN2:    begin w_ma = 36'(r_sn);          w_mb = 36'(r_sn);     end
            ewf_pkg::ST_CS2:    begin w_ma = 36'(r_cs);          w_mb = 36'(r_cs);     end
            ewf_pkg::ST_SC:     begin w_ma = 36'(r_sn);          w_mb = 36'(r_cs);     end
            ewf_pkg::ST_DEN:    begin w_ma = 36'(r_sc);          w_mb = 36'(r_kq);     end
            ewf_pkg::ST_A1:     begin w_ma = 36'(r_cs2);         w_mb = 36'(r_r);      end
            ewf_pkg::ST_A2:     begin w_ma = 36'(r_sc);          w_mb = 36'(r_r);      end
            ewf_pkg::ST_GA2:    begin w_ma = 36'(r_sn2);         w_mb = 36'(r_r);      end
            ewf_pkg::ST_BP1:    begin w_ma = 36'(r_a1);          w_mb = 36'(r_ic1);    end
            ewf_pkg::ST_BP2:    begin w_ma = 36'(r_a2);          w_mb = 36'(w_v3);     end
            ewf_pkg::ST_LP1:    begin w_ma = 36'(r_a2);          w_mb = 36'(r_ic1);    end
            ewf_pkg::ST_LP2:    begin w_ma = 36'(r_ga2);         w_mb = 36'(w_v3);     end
            ewf_pkg::ST_KG1:    begin w_ma = 36'(72090);         w_mb = 36'(r_sens);   end
            ewf_pkg::ST_KG2:    begin w_ma = 36'(r_kq);          w_mb = 36'(r_kgain);  end
            ewf_pkg::ST_WAH:    begin w_ma = 36'(r_bp);          w_mb = 36'(r_kg);     end
            ewf_pkg::ST_DRY:    begin w_ma = 36'(r_x);           w_mb = 36'(587203);   end
            ewf_pkg::ST_HP:     begin w_ma = 36'(r_hpc);         w_mb = 36'(w_hpsum);  end
            ewf_pkg::ST_OUT:    begin w_ma = 36'(r_hp);          w_mb = 36'(15434839); end
            default:            begin w_ma = '0;                 w_mb = '0;            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_sum  = r_acc + w_prod;
    assign w_sin  = 17'(ewf_pkg::f_sin_base(w_sw[23:19]) + 17'(w_prod[31:19]));
    assign w_em   = 18'(ewf_pkg::EXP_TAB[{1'b0, r_e[15:12]}] + 18'(w_prod[24:12]));
    assign w_pv   = 21'(w_prod[42:23]);
    assign w_fv   = w_prod[42:16];
    assign w_pos2 = 18'(r_pos + 18'(w_prod[30:16]));

    assign w_div_start = w_run && (i_cmd.step == ewf_pkg::ST_KQ_GO ||
                                   i_cmd.step == ewf_pkg::ST_R_GO);
    assign w_div_d = (i_cmd.step == ewf_pkg::ST_R_GO) ? r_den : ewf_pkg::DIV_DW'(r_qq);

    ewf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_wide    (i_cmd.step == ewf_pkg::ST_R_GO),
        .i_divisor (w_div_d),
        .o_busy    (w_div_busy),
        .o_quot    (w_div_q)
    );

    assign o_stat.auto_sweep = r_auto;
    assign o_stat.div_busy   = w_div_busy;

    // knobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto     <= ewf_pkg::RST_AUTO_SWEEP;
            r_pedal    <= ewf_pkg::RST_PEDAL;
            r_sens     <= ewf_pkg::RST_SENSITIVITY;
            r_att      <= ewf_pkg::RST_ATTACK;
            r_rel      <= ewf_pkg::RST_RELEASE;
            r_lfo_step <= ewf_pkg::RST_LFO_STEP;
            r_hpc      <= ewf_pkg::RST_HIGHPASS;
            r_bfn      <= ewf_pkg::RST_BASE_FREQ;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ewf_pkg::CFG_AUTO_SWEEP:  r_auto     <= i_cfg_wr_data[0];
                ewf_pkg::CFG_PEDAL:       r_pedal    <= i_cfg_wr_data[15:0];
                ewf_pkg::CFG_SENSITIVITY: r_sens     <= i_cfg_wr_data[15:0];
                ewf_pkg::CFG_ATTACK:      r_att      <= i_cfg_wr_data;
                ewf_pkg::CFG_RELEASE:     r_rel      <= i_cfg_wr_data;
                ewf_pkg::CFG_LFO_STEP:    r_lfo_step <= i_cfg_wr_data;
                ewf_pkg::CFG_HIGHPASS:    r_hpc      <= i_cfg_wr_data;
                ewf_pkg::CFG_BASE_FREQ:   r_bfn      <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // channel state, written back at the end of each word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ewf_pkg::CHANNELS; i++) begin
                r_ic1_st[i] <= '0;
                r_ic2_st[i] <= '0;
                r_env_st[i] <= '0;
                r_ph_st[i]  <= '0;
                r_hpo_st[i] <= '0;
                r_hpi_st[i] <= '0;
            end
        end else if (w_run && i_cmd.step == ewf_pkg::ST_OUT) begin
            r_ic1_st[r_chi] <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(w_ic1n));
            r_ic2_st[r_chi] <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(w_ic2n));
            r_env_st[r_chi] <= r_env;
            r_ph_st[r_chi]  <= r_ph;
            r_hpo_st[r_chi] <= r_hp;
            r_hpi_st[r_chi] <= r_mixed;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_channel;
            r_chi <= w_chi_in;
            r_x   <= i_sample_in;
            r_ic1 <= r_ic1_st[w_chi_in];
            r_ic2 <= r_ic2_st[w_chi_in];
            r_env <= r_env_st[w_chi_in];
            r_ph  <= r_ph_st[w_chi_in];
            r_hpo <= r_hpo_st[w_chi_in];
            r_hpi <= r_hpi_st[w_chi_in];
        end else if (w_run) begin
            case (i_cmd.step)
                ewf_pkg::ST_QQ:     r_qq <= 19'(19'd288358 + 19'(w_prod[33:16]));
                ewf_pkg::ST_ENV1:   r_acc <= w_prod;
                ewf_pkg::ST_ENV2:   r_env <= w_sum[47:24];
                ewf_pkg::ST_GAIN:   r_gain <= 19'(19'd144179 + 19'(w_prod[33:16]));
                ewf_pkg::ST_PICK:   r_pick <= (w_pv > 21'd65536) ? 17'd65536 : 17'(w_pv);
                ewf_pkg::ST_SIN_PH: begin
                    r_sv <= w_sin;
                    r_ph <= w_phn;
                end
                ewf_pkg::ST_LFO:    r_lfo <= w_prod[32:16];
                ewf_pkg::ST_BASE:   r_base <= 16'(16'd3277 + 16'(w_prod[29:16]));
                ewf_pkg::ST_DEPTH:  r_depth <= 17'(17'd34079 + 17'(w_prod[30:16]));
                ewf_pkg::ST_POS1:   r_pos <= 18'(18'(r_base) + 18'(w_prod[31:16]));
                ewf_pkg::ST_K1: begin
                    r_t1 <= w_prod[29:16];
                    if (!r_auto) begin
                        r_pos <= 18'(r_pedal);
                    end
                end
                ewf_pkg::ST_POS2:   r_pos <= (w_pos2 > 18'd65536) ? 18'd65536 : w_pos2;
                ewf_pkg::ST_P2:     r_p2 <= w_prod[32:16];
                ewf_pkg::ST_SHAPE:  r_shaped <= w_prod[32:16];
                ewf_pkg::ST_EXPARG: r_e <= w_prod[33:16];
                ewf_pkg::ST_EXP:    r_expv <= 20'(w_em) << r_e[17:16];
                ewf_pkg::ST_FN:     r_fn <= (w_fv > 27'(ewf_pkg::FREQ_CAP)) ?
                                            ewf_pkg::FREQ_CAP : 24'(w_fv);
                ewf_pkg::ST_SN:     r_sn <= w_sin;
                ewf_pkg::ST_CS:     r_cs <= w_sin;
                ewf_pkg::ST_SN2:    r_sn2 <= w_prod[32:0];
                ewf_pkg::ST_CS2:    r_cs2 <= w_prod[32:0];
                ewf_pkg::ST_SC:     r_sc <= w_prod[32:0];
                ewf_pkg::ST_KQ_GET: r_kq <= w_div_q;
                ewf_pkg::ST_DEN:    r_den <= 34'(34'(r_cs2) + 34'(r_sn2) + 34'(w_prod[58:24]));
                ewf_pkg::ST_R_GET:  r_r <= w_div_q;
                ewf_pkg::ST_A1:     r_a1 <= w_prod[58:32];
                ewf_pkg::ST_A2:     r_a2 <= w_prod[58:32];
                ewf_pkg::ST_GA2:    r_ga2 <= w_prod[58:32];
                ewf_pkg::ST_BP1:    r_acc <= w_prod;
                ewf_pkg::ST_BP2:    r_bp <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(w_sum >>> 24));
                ewf_pkg::ST_LP1:    r_acc <= w_prod;
                ewf_pkg::ST_LP2:    r_lp <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(r_ic2) +
                                                           ewf_pkg::SAT_W'(w_sum >>> 24));
                ewf_pkg::ST_KG1:    r_kgain <= 19'(19'd209715 + 19'(w_prod[32:16]));
                ewf_pkg::ST_KG2:    r_kg <= 25'(w_prod[44:16]);
                ewf_pkg::ST_WAH:    r_wah <= 33'(w_prod >>> 24);
                ewf_pkg::ST_DRY:    r_mixed <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(r_wah) +
                                                              ewf_pkg::SAT_W'(w_prod >>> 24));
                ewf_pkg::ST_HP:     r_hp <= ewf_pkg::f_sat32(ewf_pkg::SAT_W'(w_prod >>> 24));
                ewf_pkg::ST_OUT: begin
                    r_out_ch <= r_ch;
                    r_out_y  <= ewf_pkg::f_sat24(ewf_pkg::SAT_W'(w_prod >>> 24));
                end
                default: ;
            endcase
        end
    end

    assign o_channel_out = r_out_ch;
    assign o_sample_out  = r_out_y;

endmodule

@@ rtl/core/ewf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ewf_ctrl
// Step sequencer: accepts a word, walks the datapath steps, posts the result.
// ----------------------------------------------------------------------------
module ewf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  ewf_pkg::t_stat  i_stat,
    output ewf_pkg::t_cmd   o_cmd
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state         r_state;
    ewf_pkg::t_step r_step, w_next;
    logic           r_valid;
    logic           w_div_hold, w_out_hold, w_en, w_load;

    assign w_div_hold = (r_step == ewf_pkg::ST_KQ_GET || r_step == ewf_pkg::ST_R_GET) &&
                        i_stat.div_busy;
    assign w_out_hold = (r_step == ewf_pkg::ST_OUT) && r_valid && i_stall;
    assign w_en       = (r_state == S_RUN) && !w_div_hold && !w_out_hold;
    assign w_load     = (r_state == S_IDLE) && i_valid;

    // manual pedal skips the sweep oscillator steps
    always_comb begin
        if (!i_stat.auto_sweep && r_step == ewf_pkg::ST_PICK) begin
            w_next = ewf_pkg::ST_K1;
        end else begin
            w_next = ewf_pkg::t_step'(r_step + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ewf_pkg::ST_QQ;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_step  <= ewf_pkg::ST_QQ;
                    end
                end
                S_RUN: begin
                    if (w_en) begin
                        if (r_step == ewf_pkg::ST_OUT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= w_next;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_en && r_step == ewf_pkg::ST_OUT) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_cmd.load = w_load;
    assign o_cmd.en   = w_en;
    assign o_cmd.step = r_step;

endmodule

@@ rtl/core/envelope_lfo_wah_filter_core.sv @@
// ----------------------------------------------------------------------------
// envelope_lfo_wah_filter_core
// Auto-wah: envelope follower and sweep oscillator steer a state-variable
// bandpass, followed by dry mix, output highpass and saturation.
//
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_channel, i_sample_in
//   output    out         o_valid / i_stall    o_channel_out, o_sample_out
//   config    in          i_cfg_wr_en          i_cfg_index, i_cfg_wr_data
//
// Each word is taken in an idle cycle and then walks the step sequence; no new
// word is taken before it is done. With the sweep on that is 40 steps, 36 of
// them through one shared 36x36 multiplier, plus a wait on the restoring divide
// for the filter normalization and one on the 1/Q divide, which overlaps the
// early steps. The fixed pedal skips 5 steps and waits longer for 1/Q instead.
// Reset restores knob defaults and clears all channel state.
// A new word is taken whenever the sequencer is idle; a finished word waits
// in the output register and the last step holds while that register is full
// and the receiver stalls.
// ----------------------------------------------------------------------------
module envelope_lfo_wah_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_channel,
    input  logic signed [23:0]                i_sample_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_channel_out,
    output logic signed [23:0]                o_sample_out,
    input  logic                              i_cfg_wr_en,
    input  logic [ewf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ewf_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data
);

    ewf_pkg::t_cmd  w_cmd;
    ewf_pkg::t_stat w_stat;

    ewf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ewf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out)
    );

endmodule

@@ dv/envelope_lfo_wah_checker.sv @@
// ----------------------------------------------------------------------------
// envelope_lfo_wah_checker
// Watches the input, output and config ports of the wah core, predicts each
// output word from its own fixed-point model and compares field by field.
// ----------------------------------------------------------------------------
module envelope_lfo_wah_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_in_stall,
    input  logic                           i_channel,
    input  logic signed [23:0]             i_sample_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_channel_out,
    input  logic signed [23:0]             i_sample_out,
    input  logic                           i_cfg_wr_en,
    input  logic [ewf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ewf_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    output int                             o_pending,
    output int                             o_errors
);
    import ewf_pkg::*;

    typedef struct {
        logic               ch;
        logic signed [23:0] smp;
    } t_wah_word;

    t_wah_word wah_words_due[$];

    logic        k_auto;
    logic [63:0] k_pedal, k_sens, k_attack, k_release, k_lfo, k_hp, k_base;

    longint      bp_int [CHANNELS];
    longint      lp_int [CHANNELS];
    logic [63:0] env_lvl [CHANNELS];
    logic [63:0] lfo_ph [CHANNELS];
    longint      hp_y [CHANNELS];
    longint      hp_x [CHANNELS];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint clip32(input longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic [63:0] sine_of_turn(input logic [63:0] v);
        logic [63:0] w, idx, t;
        w = v & 64'hFFFFFF;
        if (w > 64'h800000) w = 64'h1000000 - w;
        idx = w >> 19;
        if (idx >= 16) return 64'(SIN_TAB[16]);
        t = w & 64'h7FFFF;
        return 64'(SIN_TAB[idx]) + (((64'(SIN_TAB[idx+1]) - 64'(SIN_TAB[idx])) * t) >> 19);
    endfunction

    function automatic logic [63:0] pow2_q16(input logic [63:0] e);
        logic [63:0] ip, fr, idx, t, m;
        ip  = (e >> 16) & 3;
        fr  = e & 64'hFFFF;
        idx = fr >> 12;
        t   = fr & 64'hFFF;
        m   = 64'(EXP_TAB[idx]) + (((64'(EXP_TAB[idx+1]) - 64'(EXP_TAB[idx])) * t) >> 12);
        return m << ip;
    endfunction

    function automatic logic signed [23:0] wah_sample(input logic ch,
                                                      input logic signed [23:0] xin);
        longint      x, ic1, ic2, v3, bp, lp, wah, mixed, hp, y;
        logic [63:0] s, level, env, cf, gain, pick, pos, p2, shaped, ph, sv, lfo;
        logic [63:0] fnorm, sn, cs, sn2, cs2, sc, qq, kq, den, r, a1, a2, ga2, kg;
        x   = longint'(xin);
        s   = k_sens;
        ic1 = bp_int[ch];
        ic2 = lp_int[ch];

        level = (x < 0) ? 64'(-x) : 64'(x);
        env   = env_lvl[ch];
        cf    = (level > env) ? k_attack : k_release;
        env   = (cf * env + (64'h1000000 - cf) * level) >> 24;
        env_lvl[ch] = env & 64'hFFFFFF;

        gain = 64'd144179 + ((64'd183501 * s) >> 16);
        pick = (env * gain) >> 23;
        if (pick > 65536) pick = 65536;

        if (k_auto) begin
            ph = (lfo_ph[ch] + k_lfo) & 64'hFFFFFF;
            lfo_ph[ch] = ph;
            sv  = sine_of_turn(ph);
            lfo = (sv * sv) >> 16;
            pos = 64'd3277 + ((64'd14418 * k_pedal) >> 16)
                + (((64'd34079 + ((64'd19661 * s) >> 16)) * lfo) >> 16)
                + ((((64'd9175 * s) >> 16) * pick) >> 16);
        end else begin
            pos = k_pedal + ((((64'd11796 * s) >> 16) * pick) >> 16);
        end
        if (pos > 65536) pos = 65536;

        p2     = (pos * pos) >> 16;
        shaped = (p2 * (64'd196608 - 2 * pos)) >> 16;
        fnorm  = (k_base * pow2_q16((shaped * 64'd173268) >> 16)) >> 16;
        if (fnorm > 64'(FREQ_CAP)) fnorm = 64'(FREQ_CAP);

        sn  = sine_of_turn(fnorm);
        cs  = sine_of_turn(64'h800000 - fnorm);
        qq  = 64'd288358 + ((64'd170394 * s) >> 16);
        kq  = (64'd1 << 40) / qq;
        sn2 = sn * sn;
        cs2 = cs * cs;
        sc  = sn * cs;
        den = cs2 + sn2 + ((sc * kq) >> 24);
        r   = (64'd1 << 56) / den;
        a1  = (cs2 * r) >> 32;
        a2  = (sc * r) >> 32;
        ga2 = (sn2 * r) >> 32;

        v3 = x - ic2;
        bp = clip32((longint'(a1) * ic1 + longint'(a2) * v3) >>> 24);
        lp = clip32(ic2 + ((longint'(a2) * ic1 + longint'(ga2) * v3) >>> 24));
        bp_int[ch] = clip32(2 * bp - ic1);
        lp_int[ch] = clip32(2 * lp - ic2);

        kg    = (kq * (64'd209715 + ((64'd72090 * s) >> 16))) >> 16;
        wah   = (bp * longint'(kg)) >>> 24;
        mixed = clip32(wah + ((x * 64'sd587203) >>> 24));

        hp = clip32((longint'(k_hp) * (hp_y[ch] + mixed - hp_x[ch])) >>> 24);
        hp_y[ch] = hp;
        hp_x[ch] = mixed;

        y = clip((hp * 64'sd15434839) >>> 24, -64'sd8388608, 64'sd8388607);
        return 24'(y);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_wah_word w;
        if (!i_rst_n) begin
            k_auto    = RST_AUTO_SWEEP;
            k_pedal   = 64'(RST_PEDAL);
            k_sens    = 64'(RST_SENSITIVITY);
            k_attack  = 64'(RST_ATTACK);
            k_release = 64'(RST_RELEASE);
            k_lfo     = 64'(RST_LFO_STEP);
            k_hp      = 64'(RST_HIGHPASS);
            k_base    = 64'(RST_BASE_FREQ);
            for (int i = 0; i < CHANNELS; i++) begin
                bp_int[i] = 0; lp_int[i] = 0; env_lvl[i] = 0;
                lfo_ph[i] = 0; hp_y[i] = 0; hp_x[i] = 0;
            end
            wah_words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (wah_words_due.size() == 0) begin
                    report_mismatch("unexpected word", i_sample_out, 0);
                end else begin
                    w = wah_words_due.pop_front();
                    if (i_channel_out !== w.ch)
                        report_mismatch("channel_out", i_channel_out, w.ch);
                    if (i_sample_out !== w.smp)
                        report_mismatch("sample_out", i_sample_out, w.smp);
                end
            end
            if (i_valid && !i_in_stall) begin
                w.ch  = i_channel;
                w.smp = wah_sample(1'(i_channel % CHANNELS), i_sample_in);
                wah_words_due.push_back(w);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_AUTO_SWEEP:  k_auto    = i_cfg_wr_data[0];
                    CFG_PEDAL:       k_pedal   = 64'(i_cfg_wr_data[15:0]);
                    CFG_SENSITIVITY: k_sens    = 64'(i_cfg_wr_data[15:0]);
                    CFG_ATTACK:      k_attack  = 64'(i_cfg_wr_data);
                    CFG_RELEASE:     k_release = 64'(i_cfg_wr_data);
                    CFG_LFO_STEP:    k_lfo     = 64'(i_cfg_wr_data);
                    CFG_HIGHPASS:    k_hp      = 64'(i_cfg_wr_data);
                    CFG_BASE_FREQ:   k_base    = 64'(i_cfg_wr_data);
                    default: ;
                endcase
            end
        end
        o_pending = wah_words_due.size();
    end

endmodule

@@ dv/envelope_lfo_wah_filter_core_test.sv @@
// ----------------------------------------------------------------------------
// envelope_lfo_wah_filter_core_test
// Drives directed and random sample words through the wah core over several
// knob settings and back-pressure mixes; the checker predicts every word.
// ----------------------------------------------------------------------------
module envelope_lfo_wah_filter_core_test;
    import ewf_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_channel;
    logic signed [23:0]    i_sample_in;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_channel_out;
    logic signed [23:0]    o_sample_out;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    int  words_pending;
    int  n_errors;
    int  idle_pct;
    int  stall_pct;
    int  hold_cycles;
    longint cycles;

    envelope_lfo_wah_filter_core u_dut (.*);

    envelope_lfo_wah_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_in_stall    (o_stall),
        .i_channel, .i_sample_in,
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_channel_out (o_channel_out),
        .i_sample_out  (o_sample_out),
        .i_cfg_wr_en, .i_cfg_index, .i_cfg_wr_data,
        .o_pending     (words_pending),
        .o_errors      (n_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("[envelope_lfo_wah_filter_core] ERROR");
                $finish;
            end
        end
    end

    // receiver: random stall plus one long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall = 1'b1;
            end else begin
                i_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_wr_data = data;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic send_word(input logic ch, input logic signed [23:0] smp);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_channel   = ch;
        i_sample_in = smp;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [23:0] knob24();
        case ($urandom_range(3))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed(12'($urandom)));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [23:0] tone;
        i_rst_n = 1'b0; i_valid = 1'b0; i_channel = 1'b0; i_sample_in = '0;
        i_cfg_wr_en = 1'b0; i_cfg_index = '0; i_cfg_wr_data = '0;
        idle_pct = 0; stall_pct = 0; hold_cycles = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: defaults, then extremes of fields and knobs
        send_word(1'b0, 24'sh7FFFFF);
        send_word(1'b1, 24'sh800000);
        send_word(1'b0, 24'sd0);
        send_word(1'b1, -24'sd1);
        send_word(1'b0, 24'sh555555);
        send_word(1'b1, 24'shAAAAAA);
        drain();
        cfg_write(CFG_AUTO_SWEEP, 24'd0);
        cfg_write(CFG_PEDAL, 24'd65535);
        cfg_write(CFG_SENSITIVITY, 24'd65535);
        cfg_write(CFG_BASE_FREQ, 24'hFFFFFF);
        cfg_write(CFG_HIGHPASS, 24'hFFFFFF);
        cfg_write(CFG_ATTACK, 24'd0);
        cfg_write(CFG_RELEASE, 24'hFFFFFF);
        for (int i = 0; i < 6; i++) send_word(i[0], i[1] ? 24'sh7FFFFF : 24'sh800000);
        drain();
        cfg_write(CFG_AUTO_SWEEP, 24'd1);
        cfg_write(CFG_PEDAL, 24'd0);
        cfg_write(CFG_SENSITIVITY, 24'd0);
        cfg_write(CFG_BASE_FREQ, 24'd0);
        cfg_write(CFG_LFO_STEP, 24'hFFFFFF);
        cfg_write(CFG_HIGHPASS, 24'd0);
        cfg_write(CFG_ATTACK, 24'hFFFFFF);
        cfg_write(CFG_RELEASE, 24'd0);
        for (int i = 0; i < 6; i++) send_word(i[0], rand_sample());
        drain();

        // random phases over knob settings and flow-control mixes
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_AUTO_SWEEP, 24'($urandom_range(1)));
            cfg_write(CFG_PEDAL, 24'(knob24() & 24'hFFFF));
            cfg_write(CFG_SENSITIVITY, 24'(knob24() & 24'hFFFF));
            cfg_write(CFG_ATTACK, ($urandom_range(1) ? knob24() : 24'd16707457));
            cfg_write(CFG_RELEASE, ($urandom_range(1) ? knob24() : 24'd16774527));
            cfg_write(CFG_LFO_STEP, ($urandom_range(1) ? knob24() : 24'($urandom_range(5000))));
            cfg_write(CFG_HIGHPASS, ($urandom_range(1) ? knob24() : 24'd16571200));
            cfg_write(CFG_BASE_FREQ, ($urandom_range(1) ? knob24()
                                                        : 24'($urandom_range(500000))));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            if (ph == 2) hold_cycles = 1500;
            for (int i = 0; i < 78; i++) begin
                // about half of the words take a random sample shifted right by up to 8 bits, alternating channels
                if ($urandom_range(1)) begin
                    tone = 24'($signed(24'($urandom)) >>> $urandom_range(8));
                    send_word(i[0], tone);
                end else begin
                    send_word(1'($urandom), rand_sample());
                end
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("[envelope_lfo_wah_filter_core] OK");
        end else begin
            $display("[envelope_lfo_wah_filter_core] ERROR");
        end
        $finish;
    end

endmodule
